### design/case_folding_symbol_interner_macros.svh
// ----------------------------------------------------------------------------
// Symbol interner assertion macros
// Shared assertion forms for the interner design.
// ----------------------------------------------------------------------------
`ifndef CASE_FOLDING_SYMBOL_INTERNER_MACROS_SVH
`define CASE_FOLDING_SYMBOL_INTERNER_MACROS_SVH
// Implication checked at every edge outside reset.
`define CFSI_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define CFSI_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

### design/cfsi_pkg.sv
// ----------------------------------------------------------------------------
// Symbol interner package
// Types, constants and helper functions of the symbol interner.
// ----------------------------------------------------------------------------
package cfsi_pkg;
    localparam int MAX_LEN_DEF     = 32;
    localparam int SLOTS_DEF       = 512;
    localparam int MAX_SYMBOLS_DEF = 256;

    localparam logic [31:0] FNV_BASIS = 32'h811C9DC5;
    localparam logic [31:0] FNV_PRIME = 32'h01000193;

    localparam logic [7:0] CHAR_UPPER_A = 8'h41;
    localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
    localparam logic [7:0] CASE_OFFSET  = 8'h20;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_TOO_LONG = 2'd1;
    localparam logic [1:0] ST_FULL     = 2'd2;

    typedef struct packed {
        logic [7:0] char_in;
        logic       last_byte;
    } in_item_t;

    typedef struct packed {
        logic [1:0] status;
        logic [8:0] symbol_id;
    } out_item_t;

    function automatic logic [7:0] fold_case(input logic [7:0] c);
        logic [7:0] r;
        r = c;
        if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z)
        begin
            r = c + CASE_OFFSET;
        end
        return r;
    endfunction
endpackage

### design/case_folding_symbol_interner.sv
// ----------------------------------------------------------------------------
// Case-folding symbol interner
// Folds, buffers and hashes symbol bytes, then interns the symbol by linear
// probing over a slot table with byte-wise text compares.
// ----------------------------------------------------------------------------
// A byte within MAX_LEN passes the accept state and the hash multiply; a last
// one adds the probe start, a check per probed slot, a read and a compare on the
// shared comparator per compared byte, a read and a write per byte copied on an
// insert, and output. An overlong byte takes the accept state only, then output
// if last. After reset it clears the slot table, busy high, then takes items.
module case_folding_symbol_interner #(
    parameter int MAX_LEN     = cfsi_pkg::MAX_LEN_DEF,
    parameter int SLOTS       = cfsi_pkg::SLOTS_DEF,
    parameter int MAX_SYMBOLS = cfsi_pkg::MAX_SYMBOLS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  cfsi_pkg::in_item_t  in_item,
    output logic                done,
    output cfsi_pkg::out_item_t out_item
);
    import cfsi_pkg::*;
    `include "case_folding_symbol_interner_macros.svh"

    localparam int SW = $clog2(SLOTS);
    localparam int LW = $clog2(MAX_LEN + 1);
    localparam int PW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
    localparam int IW = $clog2(MAX_SYMBOLS + 1);
    localparam int TW = SW + PW;
    localparam int CW = SW + 1;

    localparam logic [3:0] S_CLEAR = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_HASH  = 4'd2;
    localparam logic [3:0] S_PRB   = 4'd3;
    localparam logic [3:0] S_PCHK  = 4'd4;
    localparam logic [3:0] S_CRD   = 4'd5;
    localparam logic [3:0] S_CCMP  = 4'd6;
    localparam logic [3:0] S_COPYR = 4'd7;
    localparam logic [3:0] S_COPYW = 4'd8;
    localparam logic [3:0] S_OUT   = 4'd9;

    logic [IW-1:0] slot_id_mem [SLOTS];
    logic [LW-1:0] slot_len_mem [SLOTS];
    logic [7:0]    slot_text_mem [SLOTS * (1 << PW)];
    logic [7:0]    pend_mem [MAX_LEN];

    logic [3:0]    state_reg, state_next;
    logic [SW-1:0] addr_reg, addr_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [LW-1:0] plen_reg, plen_next;
    logic [PW-1:0] bidx_reg, bidx_next;
    logic          over_reg, over_next;
    logic [31:0]   hash_reg, hash_next;
    logic          last_reg, last_next;
    logic [IW-1:0] count_reg, count_next;
    logic [1:0]    st_reg, st_next;
    logic [8:0]    id_reg, id_next;

    logic [IW-1:0] rd_id;
    logic [LW-1:0] rd_len;
    logic [7:0]    rd_text;
    logic [7:0]    rd_pend;

    logic          id_we, len_we, text_we, pend_we;
    logic [IW-1:0] id_wd;
    logic [TW-1:0] text_addr;
    logic [PW-1:0] pend_addr;

    assign text_addr = {addr_reg, bidx_reg};
    assign pend_addr = (state_reg == S_IDLE) ? plen_reg[PW-1:0] : bidx_reg;

    always_ff @(posedge clk)
    begin
        if (id_we)
        begin
            slot_id_mem[addr_reg] <= id_wd;
        end
        if (len_we)
        begin
            slot_len_mem[addr_reg] <= plen_reg;
        end
        if (text_we)
        begin
            slot_text_mem[text_addr] <= rd_pend;
        end
        if (pend_we)
        begin
            pend_mem[pend_addr] <= fold_case(in_item.char_in);
        end
        rd_id   <= slot_id_mem[addr_next];
        rd_len  <= slot_len_mem[addr_next];
        rd_text <= slot_text_mem[{addr_next, bidx_next}];
        rd_pend <= pend_mem[bidx_next];
    end

    always_comb
    begin
        state_next = state_reg;
        addr_next  = addr_reg;
        cnt_next   = cnt_reg;
        plen_next  = plen_reg;
        bidx_next  = bidx_reg;
        over_next  = over_reg;
        hash_next  = hash_reg;
        last_next  = last_reg;
        count_next = count_reg;
        st_next    = st_reg;
        id_next    = id_reg;
        id_we      = 1'b0;
        len_we     = 1'b0;
        text_we    = 1'b0;
        pend_we    = 1'b0;
        id_wd      = '0;
        unique case (state_reg)
            S_CLEAR:
            begin
                id_we = 1'b1;
                addr_next = addr_reg + 1'b1;
                if (addr_reg == SW'(SLOTS - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (start)
                begin
                    last_next = in_item.last_byte;
                    if (plen_reg < LW'(MAX_LEN))
                    begin
                        pend_we = 1'b1;
                        plen_next = plen_reg + 1'b1;
                        hash_next = hash_reg ^ {24'd0, fold_case(in_item.char_in)};
                        state_next = S_HASH;
                    end
                    else
                    begin
                        over_next = 1'b1;
                        if (in_item.last_byte)
                        begin
                            st_next = ST_TOO_LONG;
                            id_next = '0;
                            state_next = S_OUT;
                        end
                    end
                end
            end
            S_HASH:
            begin
                hash_next = hash_reg * FNV_PRIME;
                if (!last_reg)
                begin
                    state_next = S_IDLE;
                end
                else if (over_reg)
                begin
                    st_next = ST_TOO_LONG;
                    id_next = '0;
                    state_next = S_OUT;
                end
                else
                begin
                    state_next = S_PRB;
                end
            end
            S_PRB:
            begin
                addr_next = hash_reg[SW-1:0];
                cnt_next = '0;
                bidx_next = '0;
                state_next = S_PCHK;
            end
            S_PCHK:
            begin
                bidx_next = '0;
                if (rd_id == '0)
                begin
                    if (count_reg >= IW'(MAX_SYMBOLS))
                    begin
                        st_next = ST_FULL;
                        id_next = '0;
                        state_next = S_OUT;
                    end
                    else
                    begin
                        count_next = count_reg + 1'b1;
                        id_we = 1'b1;
                        id_wd = count_reg + 1'b1;
                        len_we = 1'b1;
                        st_next = ST_OK;
                        id_next = 9'(count_reg + 1'b1);
                        state_next = S_COPYR;
                    end
                end
                else if (rd_len == plen_reg)
                begin
                    state_next = S_CRD;
                end
                else
                begin
                    addr_next = addr_reg + 1'b1;
                    cnt_next = cnt_reg + 1'b1;
                    if (cnt_reg == CW'(SLOTS - 1))
                    begin
                        st_next = ST_FULL;
                        id_next = '0;
                        state_next = S_OUT;
                    end
                    else
                    begin
                        state_next = S_PCHK;
                    end
                end
            end
            S_CRD:
            begin
                state_next = S_CCMP;
            end
            S_CCMP:
            begin
                if (rd_text != rd_pend)
                begin
                    bidx_next = '0;
                    addr_next = addr_reg + 1'b1;
                    cnt_next = cnt_reg + 1'b1;
                    if (cnt_reg == CW'(SLOTS - 1))
                    begin
                        st_next = ST_FULL;
                        id_next = '0;
                        state_next = S_OUT;
                    end
                    else
                    begin
                        state_next = S_PCHK;
                    end
                end
                else if ({1'b0, bidx_reg} == LW'(plen_reg - 1'b1))
                begin
                    st_next = ST_OK;
                    id_next = 9'(rd_id);
                    state_next = S_OUT;
                end
                else
                begin
                    bidx_next = bidx_reg + 1'b1;
                    state_next = S_CRD;
                end
            end
            S_COPYR:
            begin
                state_next = S_COPYW;
            end
            S_COPYW:
            begin
                text_we = 1'b1;
                if ({1'b0, bidx_reg} == LW'(plen_reg - 1'b1))
                begin
                    state_next = S_OUT;
                end
                else
                begin
                    bidx_next = bidx_reg + 1'b1;
                    state_next = S_COPYR;
                end
            end
            S_OUT:
            begin
                plen_next = '0;
                over_next = 1'b0;
                hash_next = FNV_BASIS;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            addr_reg  <= '0;
            cnt_reg   <= '0;
            plen_reg  <= '0;
            bidx_reg  <= '0;
            over_reg  <= 1'b0;
            hash_reg  <= FNV_BASIS;
            last_reg  <= 1'b0;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            addr_reg  <= addr_next;
            cnt_reg   <= cnt_next;
            plen_reg  <= plen_next;
            bidx_reg  <= bidx_next;
            over_reg  <= over_next;
            hash_reg  <= hash_next;
            last_reg  <= last_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        st_reg   <= st_next;
        id_reg   <= id_next;
    end

    assign busy = (state_reg != S_IDLE);
    assign done = (state_reg == S_OUT);
    assign out_item.status = st_reg;
    assign out_item.symbol_id = id_reg;

    `CFSI_ASSERT_IMP(a_err_zero_id, clk, rst_n, done && st_reg != ST_OK, id_reg == '0)
    `CFSI_ASSERT_IMP(a_ok_nonzero, clk, rst_n, done && st_reg == ST_OK, id_reg != '0)
    `CFSI_ASSERT_NEXT(a_out_clears, clk, rst_n, done, plen_reg == '0 && !over_reg)
    `CFSI_ASSERT_IMP(a_count_max, clk, rst_n, 1'b1, count_reg <= IW'(MAX_SYMBOLS))
endmodule

### tb/sv/case_folding_symbol_interner_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Symbol interner checker
// Watches accepted bytes and returned ids. It keeps its own symbol table,
// derives the expected status and id of every finished symbol and compares.
// ----------------------------------------------------------------------------
module case_folding_symbol_interner_checker
    import cfsi_pkg::*;
#(
    parameter int MAX_LEN     = MAX_LEN_DEF,
    parameter int SLOTS       = SLOTS_DEF,
    parameter int MAX_SYMBOLS = MAX_SYMBOLS_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    input  logic      busy,
    input  in_item_t  in_item,
    input  logic      done,
    input  out_item_t out_item,
    output int        fail_count,
    output int        pending_ids,
    output int        symbols_seen,
    output int        errors_seen
);
    logic [15:0] tbl_id [SLOTS];
    logic [5:0]  tbl_len [SLOTS];
    logic [7:0]  tbl_text [SLOTS][MAX_LEN];
    int          interned;
    logic [7:0]  cur_text [MAX_LEN];
    int          cur_len;
    logic        cur_overlong;
    logic [31:0] cur_hash;
    out_item_t   id_queue [$];

    function automatic out_item_t intern_symbol();
        out_item_t r;
        int pos;
        int free_pos;
        logic same;
        r = '0;
        free_pos = -1;
        for (int i = 0; i < SLOTS; i++)
        begin
            pos = (cur_hash + i) & (SLOTS - 1);
            if (tbl_id[pos] == 0)
            begin
                free_pos = pos;
                break;
            end
            same = (tbl_len[pos] == cur_len);
            for (int k = 0; k < cur_len; k++)
            begin
                if (same && tbl_text[pos][k] != cur_text[k])
                begin
                    same = 1'b0;
                end
            end
            if (same)
            begin
                r.status = ST_OK;
                r.symbol_id = tbl_id[pos][8:0];
                return r;
            end
        end
        if (free_pos < 0 || interned >= MAX_SYMBOLS)
        begin
            r.status = ST_FULL;
            return r;
        end
        interned++;
        tbl_id[free_pos] = interned;
        tbl_len[free_pos] = cur_len;
        for (int k = 0; k < cur_len; k++)
        begin
            tbl_text[free_pos][k] = cur_text[k];
        end
        r.status = ST_OK;
        r.symbol_id = interned[8:0];
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        logic [7:0] c;
        out_item_t  want;
        if (!rst_n)
        begin
            foreach (tbl_id[i])
            begin
                tbl_id[i] = '0;
            end
            interned = 0;
            cur_len = 0;
            cur_overlong = 1'b0;
            cur_hash = FNV_BASIS;
            id_queue.delete();
            fail_count = 0;
            pending_ids = 0;
            symbols_seen = 0;
            errors_seen = 0;
        end
        else
        begin
            if (done)
            begin
                if (id_queue.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                    begin
                        $display("unexpected result status=%0d id=%0d",
                                 out_item.status, out_item.symbol_id);
                    end
                end
                else
                begin
                    want = id_queue.pop_front();
                    if (out_item.status !== want.status
                        || out_item.symbol_id !== want.symbol_id)
                    begin
                        fail_count++;
                        if (fail_count <= 10)
                        begin
                            $display("result differs: expected status=%0d id=%0d, got status=%0d id=%0d",
                                     want.status, want.symbol_id,
                                     out_item.status, out_item.symbol_id);
                        end
                    end
                end
            end
            if (start && !busy)
            begin
                c = in_item.char_in;
                if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z)
                begin
                    c = c + CASE_OFFSET;
                end
                if (cur_len < MAX_LEN)
                begin
                    cur_text[cur_len] = c;
                    cur_len++;
                    cur_hash = (cur_hash ^ {24'd0, c}) * FNV_PRIME;
                end
                else
                begin
                    cur_overlong = 1'b1;
                end
                if (in_item.last_byte)
                begin
                    if (cur_overlong)
                    begin
                        want.status = ST_TOO_LONG;
                        want.symbol_id = '0;
                    end
                    else
                    begin
                        want = intern_symbol();
                    end
                    if (want.status != ST_OK)
                    begin
                        errors_seen++;
                    end
                    symbols_seen++;
                    id_queue.push_back(want);
                    cur_len = 0;
                    cur_overlong = 1'b0;
                    cur_hash = FNV_BASIS;
                end
            end
            pending_ids = id_queue.size();
        end
    end
endmodule

### tb/sv/case_folding_symbol_interner_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Symbol interner testbench
// Sends directed and random symbols byte by byte with random gaps, including
// repeats in mixed case, overlong symbols and enough distinct symbols to fill
// the table. The checker compares every returned id.
// ----------------------------------------------------------------------------
module case_folding_symbol_interner_tb;
    import cfsi_pkg::*;

    logic      clk;
    logic      rst_n;
    logic      start;
    logic      busy;
    in_item_t  in_item;
    logic      done;
    out_item_t out_item;
    int        fail_count;
    int        pending_ids;
    int        symbols_seen;
    int        errors_seen;
    int        bytes_sent;
    longint    cycle_count;
    logic [7:0] word_pool [24][$];

    case_folding_symbol_interner i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .busy     (busy),
        .in_item  (in_item),
        .done     (done),
        .out_item (out_item)
    );

    case_folding_symbol_interner_checker i_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .in_item      (in_item),
        .done         (done),
        .out_item     (out_item),
        .fail_count   (fail_count),
        .pending_ids  (pending_ids),
        .symbols_seen (symbols_seen),
        .errors_seen  (errors_seen)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #6 clk = ~clk;
        end
    end

    initial
    begin
        cycle_count = 0;
        forever
        begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count > 3000000)
            begin
                $display("case_folding_symbol_interner: mismatch");
                $finish;
            end
        end
    end

    task automatic idle_gap();
        int n;
        if ($urandom_range(0, 2) == 0)
        begin
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) : $urandom_range(1, 3);
            start <= 1'b0;
            repeat (n) @(posedge clk);
        end
    endtask

    task automatic send_byte(input logic [7:0] c, input logic last);
        start <= 1'b1;
        in_item.char_in <= c;
        in_item.last_byte <= last;
        @(posedge clk);
        while (busy)
        begin
            @(posedge clk);
        end
        bytes_sent++;
        idle_gap();
    endtask

    task automatic send_symbol(input logic [7:0] text [$], input logic mix_case);
        logic [7:0] c;
        for (int k = 0; k < text.size(); k++)
        begin
            c = text[k];
            if (mix_case && c >= 8'h61 && c <= 8'h7A && $urandom_range(0, 1))
            begin
                c = c - CASE_OFFSET;
            end
            send_byte(c, k == text.size() - 1);
        end
    endtask

    task automatic send_random(input int len, input logic any_byte);
        logic [7:0] t [$];
        for (int k = 0; k < len; k++)
        begin
            t.push_back(any_byte ? 8'($urandom) : 8'($urandom_range(8'h61, 8'h7A)));
        end
        send_symbol(t, 1'b0);
    endtask

    initial
    begin
        logic [7:0] t [$];
        int len;
        rst_n = 1'b0;
        start = 1'b0;
        in_item = '0;
        bytes_sent = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        t = '{8'h00};
        send_symbol(t, 1'b0);
        t = '{8'hFF};
        send_symbol(t, 1'b0);
        t = '{8'h41, 8'h5A, 8'h40, 8'h5B};
        send_symbol(t, 1'b0);
        t = '{8'h61, 8'h7A, 8'h40, 8'h5B};
        send_symbol(t, 1'b0);
        send_random(32, 1'b1);
        send_random(33, 1'b1);

        start <= 1'b0;
        @(posedge clk);
        wait (pending_ids == 0);
        repeat (200) @(posedge clk);

        for (int w = 0; w < 24; w++)
        begin
            len = ($urandom_range(0, 15) == 0) ? $urandom_range(20, 32) : $urandom_range(1, 5);
            for (int k = 0; k < len; k++)
            begin
                word_pool[w].push_back(8'($urandom_range(8'h61, 8'h7A)));
            end
        end

        while (bytes_sent < 340)
        begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3:
                begin
                    send_symbol(word_pool[$urandom_range(0, 23)], 1'b1);
                end
                4, 5, 6:
                begin
                    send_random($urandom_range(1, 3), 1'b0);
                end
                7:
                begin
                    send_random($urandom_range(1, 4), 1'b1);
                end
                8:
                begin
                    send_random($urandom_range(33, 36), 1'b1);
                end
                default:
                begin
                    send_random($urandom_range(6, 32), 1'b1);
                end
            endcase
        end

        for (int s = 0; s < 280; s++)
        begin
            t.delete();
            t.push_back(8'(s));
            t.push_back(8'(s >> 8));
            send_symbol(t, 1'b0);
        end
        for (int w = 0; w < 24; w++)
        begin
            send_symbol(word_pool[w], 1'b1);
        end

        start <= 1'b0;
        @(posedge clk);
        wait (pending_ids == 0);
        repeat (200) @(posedge clk);
        $display("Sent %0d bytes forming %0d symbols; %0d ended in too-long or full status.",
                 bytes_sent, symbols_seen, errors_seen);
        if (fail_count == 0 && pending_ids == 0)
        begin
            $display("case_folding_symbol_interner: match");
        end
        else
        begin
            $display("case_folding_symbol_interner: mismatch");
        end
        $finish;
    end
endmodule
